// ----- hw/rtl/rbp_pkg.sv -----
// Shared constants, codes and types of the refcounted block pool.
package rbp_pkg;

    localparam int POOL_BLOCKS = 256;
    localparam int CACHE_SLOTS = 512;
    localparam int BID_W       = $clog2(POOL_BLOCKS);
    localparam int SLOT_W      = $clog2(CACHE_SLOTS);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int DEPTH_W     = BID_W + 1;
    localparam int KEY_W       = 64;
    localparam int LU_W        = 64;
    localparam int REF_W       = 16;
    localparam int BI_W        = LU_W + 1 + REF_W;
    localparam int SL_W        = KEY_W + BID_W;
    localparam int EVICT_LIMIT = CACHE_SLOTS * 3 / 4;

    typedef enum logic [3:0] {
        OP_ALLOC  = 4'd0,
        OP_FREE   = 4'd1,
        OP_INCREF = 4'd2,
        OP_DECREF = 4'd3,
        OP_COW    = 4'd4,
        OP_LOOKUP = 4'd5,
        OP_INSERT = 4'd6,
        OP_EVICT  = 4'd7,
        OP_CLEAR  = 4'd8
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NOMEM   = 2'd2
    } t_status;

    typedef enum logic [14:0] {
        S_CLR      = 15'h0001,
        S_IDLE     = 15'h0002,
        S_DISP     = 15'h0004,
        S_BCHK     = 15'h0008,
        S_POP_B    = 15'h0010,
        S_POP_CHK  = 15'h0020,
        S_PURGE    = 15'h0040,
        S_POP_WR   = 15'h0080,
        S_COW_RD   = 15'h0100,
        S_COW_WR   = 15'h0200,
        S_LK_SCAN  = 15'h0400,
        S_LK_CHK   = 15'h0800,
        S_EV_SCAN  = 15'h1000,
        S_INS_SCAN = 15'h2000,
        S_DONE     = 15'h4000
    } t_state;

endpackage

// ----- hw/rtl/rbp_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
module rbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/refcounted_block_pool_with_prefix_cache_core.sv -----
// Top level: block allocator, reference counts and prefix cache sequencer.
// Alloc, and a cow that copies, pop a block off the free stack; reusing a cached block adds
// a purge scan of the slots. Lookup and insert probe the slots from the key's low bits;
// evict and clear cover every slot, and an insert over 3/4 full runs an evict scan first.
// One item at a time; the next is taken in the cycle after its result is loaded. Reset
// runs a clear of all CACHE_SLOTS slots with o_ready low.
module refcounted_block_pool_with_prefix_cache_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [3:0]             i_opcode,
    input  logic [15:0]            i_block_id,
    input  logic [rbp_pkg::KEY_W-1:0] i_key,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [1:0]             o_status,
    output logic [15:0]            o_result_block,
    output logic                   o_hit,
    output logic                   o_copied,
    output logic [15:0]            o_free_blocks
);
    import rbp_pkg::*;

    t_state r_state, n_state;
    logic [3:0]         r_op, n_op;
    logic [15:0]        r_id, n_id;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [1:0]         r_st, n_st;
    logic [BID_W-1:0]   r_res, n_res;
    logic               r_hit, n_hit, r_cop, n_cop;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [LU_W-1:0]    r_clock, n_clock;
    logic [POOL_BLOCKS-1:0] r_fval, n_fval, r_bval, n_bval;
    logic               r_fv_q, r_bv_q;
    logic [BID_W-1:0]   r_fra_q;
    logic [SLOT_W:0]    r_scan, n_scan;
    logic               r_pv, n_pv, r_pv2, n_pv2;
    logic [SLOT_W-1:0]  r_ps, r_ps2, r_hs, n_hs;
    logic [BID_W-1:0]   r_pb2, r_new, n_new, r_bestb, n_bestb;
    logic [BI_W-1:0]    r_nw, n_nw, r_bw, n_bw, r_bestw, n_bestw;
    logic               r_found, n_found, r_ev_ins, n_ev_ins, r_clr_out, n_clr_out;
    logic [LU_W-1:0]    r_best, n_best;
    logic [SLOT_W-1:0]  r_bests, n_bests;
    logic               r_ov, n_ov;
    logic [1:0]         r_o_st, n_o_st;
    logic [BID_W-1:0]   r_o_res, n_o_res;
    logic               r_o_hit, n_o_hit, r_o_cop, n_o_cop;
    logic [DEPTH_W-1:0] r_o_free, n_o_free;

    logic               s_we, b_we, f_we;
    logic [SLOT_W-1:0]  s_waddr, s_raddr;
    logic [SL_W-1:0]    s_wdata, s_rdata;
    logic [BID_W-1:0]   b_waddr, b_raddr, f_waddr, f_raddr, f_wdata, f_rdata;
    logic [BI_W-1:0]    b_wdata, b_rdata;

    logic [BI_W-1:0]    bw_eff;
    logic [BID_W-1:0]   f_eff;
    logic [KEY_W-1:0]   sk;
    logic [BID_W-1:0]   sb;
    logic [REF_W-1:0]   bref;
    logic               issue, id_ok, full;

    rbp_ram #(.WIDTH(SL_W), .DEPTH(CACHE_SLOTS)) u_slots (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );

    rbp_ram #(.WIDTH(BI_W), .DEPTH(POOL_BLOCKS)) u_binfo (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_waddr), .i_wdata(b_wdata),
        .i_raddr(b_raddr), .o_rdata(b_rdata)
    );

    rbp_ram #(.WIDTH(BID_W), .DEPTH(POOL_BLOCKS)) u_stack (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_raddr(f_raddr), .o_rdata(f_rdata)
    );

    assign bw_eff = r_bv_q ? b_rdata : '0;
    assign f_eff  = r_fv_q ? f_rdata : (BID_W'(POOL_BLOCKS - 1) - r_fra_q);
    assign sk     = s_rdata[SL_W-1:BID_W];
    assign sb     = s_rdata[BID_W-1:0];
    assign bref   = bw_eff[REF_W-1:0];
    assign issue  = !r_scan[SLOT_W];
    assign id_ok  = r_id < 16'(POOL_BLOCKS);
    assign full   = r_depth >= DEPTH_W'(POOL_BLOCKS);

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_ov;
    assign o_status       = r_o_st;
    assign o_result_block = 16'(r_o_res);
    assign o_hit          = r_o_hit;
    assign o_copied       = r_o_cop;
    assign o_free_blocks  = 16'(r_o_free);

    always_comb begin
        n_state = r_state;   n_op = r_op;       n_id = r_id;       n_key = r_key;
        n_st = r_st;         n_res = r_res;     n_hit = r_hit;     n_cop = r_cop;
        n_depth = r_depth;   n_cnt = r_cnt;     n_clock = r_clock;
        n_fval = r_fval;     n_bval = r_bval;   n_scan = r_scan;
        n_pv = 1'b0;         n_pv2 = 1'b0;      n_hs = r_hs;       n_new = r_new;
        n_nw = r_nw;         n_bw = r_bw;       n_found = r_found; n_best = r_best;
        n_bests = r_bests;   n_bestb = r_bestb; n_bestw = r_bestw;
        n_ev_ins = r_ev_ins; n_clr_out = r_clr_out;
        n_ov = r_ov & ~i_ready;
        n_o_st = r_o_st;     n_o_res = r_o_res; n_o_hit = r_o_hit; n_o_cop = r_o_cop;
        n_o_free = r_o_free;
        s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_raddr = '0;
        b_we = 1'b0; b_waddr = '0; b_wdata = '0; b_raddr = r_id[BID_W-1:0];
        f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = '0;

        case (r_state)
            S_CLR: begin
                s_we    = 1'b1;
                s_waddr = r_scan[SLOT_W-1:0];
                n_scan  = r_scan + 1'b1;
                if (r_scan[SLOT_W-1:0] == '1) begin
                    n_cnt   = '0;
                    n_scan  = '0;
                    n_state = r_clr_out ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_op = i_opcode; n_id = i_block_id; n_key = i_key;
                    n_st = ST_OK; n_res = '0; n_hit = 1'b0; n_cop = 1'b0;
                    n_clr_out = 1'b0;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_scan   = '0;
                n_found  = 1'b0;
                n_ev_ins = 1'b0;
                case (r_op)
                    OP_ALLOC: begin
                        if (r_depth == '0) begin
                            n_st = ST_NOMEM; n_state = S_DONE;
                        end else begin
                            f_raddr = BID_W'(r_depth - 1'b1);
                            n_state = S_POP_B;
                        end
                    end
                    OP_FREE: begin
                        if (!id_ok || full) begin
                            n_st = ST_INVALID; n_state = S_DONE;
                        end else begin
                            n_state = S_BCHK;
                        end
                    end
                    OP_INCREF, OP_DECREF, OP_COW: begin
                        if (!id_ok) begin
                            n_st = ST_INVALID; n_state = S_DONE;
                        end else begin
                            n_state = S_BCHK;
                        end
                    end
                    OP_LOOKUP: begin
                        if (r_key == '0) begin
                            n_st = ST_INVALID; n_state = S_DONE;
                        end else begin
                            n_state = S_LK_SCAN;
                        end
                    end
                    OP_INSERT: begin
                        if (r_key == '0 || !id_ok) begin
                            n_st = ST_INVALID; n_state = S_DONE;
                        end else begin
                            n_state = S_BCHK;
                        end
                    end
                    OP_EVICT: begin
                        n_state = (r_cnt == '0) ? S_DONE : S_EV_SCAN;
                    end
                    OP_CLEAR: begin
                        n_clr_out = 1'b1;
                        n_state   = S_CLR;
                    end
                    default: begin
                        n_st = ST_INVALID; n_state = S_DONE;
                    end
                endcase
            end
            S_BCHK: begin
                n_bw    = bw_eff;
                n_state = S_DONE;
                b_waddr = r_id[BID_W-1:0];
                f_waddr = r_depth[BID_W-1:0];
                f_wdata = r_id[BID_W-1:0];
                case (r_op)
                    OP_FREE: begin
                        b_we = 1'b1; b_wdata = {bw_eff[BI_W-1:REF_W], REF_W'(0)};
                        f_we = 1'b1; n_depth = r_depth + 1'b1;
                    end
                    OP_INCREF: begin
                        if (bref == '1) begin
                            n_st = ST_INVALID;
                        end else begin
                            b_we = 1'b1; b_wdata = {bw_eff[BI_W-1:REF_W], bref + 1'b1};
                        end
                    end
                    OP_DECREF: begin
                        if (bref == '0) begin
                            n_st = ST_INVALID;
                        end else if (bref == REF_W'(1)) begin
                            if (full) begin
                                n_st = ST_INVALID;
                            end else begin
                                b_we = 1'b1; b_wdata = {bw_eff[BI_W-1:REF_W], REF_W'(0)};
                                f_we = 1'b1; n_depth = r_depth + 1'b1;
                            end
                        end else begin
                            b_we = 1'b1; b_wdata = {bw_eff[BI_W-1:REF_W], bref - 1'b1};
                        end
                    end
                    OP_COW: begin
                        if (bref <= REF_W'(1)) begin
                            n_res = r_id[BID_W-1:0];
                        end else if (r_depth == '0) begin
                            n_st = ST_NOMEM;
                        end else begin
                            f_raddr = BID_W'(r_depth - 1'b1);
                            n_state = S_POP_B;
                        end
                    end
                    OP_INSERT: begin
                        if (bref != '0) begin
                            if (r_cnt > CNT_W'(EVICT_LIMIT)) begin
                                n_ev_ins = 1'b1;
                                n_state  = S_EV_SCAN;
                            end else begin
                                n_state = S_INS_SCAN;
                            end
                        end
                    end
                    default: begin
                        n_st = ST_INVALID;
                    end
                endcase
            end
            S_POP_B: begin
                n_new   = f_eff;
                b_raddr = f_eff;
                n_state = S_POP_CHK;
            end
            S_POP_CHK: begin
                n_nw    = bw_eff;
                n_scan  = '0;
                n_state = bw_eff[REF_W] ? S_PURGE : S_POP_WR;
            end
            S_PURGE: begin
                s_raddr = r_scan[SLOT_W-1:0];
                n_pv    = issue;
                n_scan  = r_scan + SLOT_W'(issue);
                if (r_pv && sk != '0 && sb == r_new) begin
                    s_we = 1'b1; s_waddr = r_ps;
                    if (r_cnt != '0) n_cnt = r_cnt - 1'b1;
                end
                if (!issue && !r_pv) n_state = S_POP_WR;
            end
            S_POP_WR: begin
                b_we    = 1'b1;
                b_waddr = r_new;
                b_wdata = {r_nw[BI_W-1:REF_W+1], 1'b0, REF_W'(1)};
                n_depth = r_depth - 1'b1;
                n_res   = r_new;
                n_state = (r_op == OP_COW) ? S_COW_RD : S_DONE;
            end
            S_COW_RD: begin
                n_state = S_COW_WR;
            end
            S_COW_WR: begin
                b_we    = 1'b1;
                b_waddr = r_id[BID_W-1:0];
                b_wdata = {bw_eff[BI_W-1:REF_W], bref - 1'b1};
                n_cop   = 1'b1;
                n_state = S_DONE;
            end
            S_LK_SCAN: begin
                s_raddr = r_key[SLOT_W-1:0] + r_scan[SLOT_W-1:0];
                if (r_pv && sk == r_key) begin
                    n_new   = sb;
                    b_raddr = sb;
                    n_hs    = r_ps;
                    n_state = S_LK_CHK;
                end else begin
                    n_pv   = issue;
                    n_scan = r_scan + SLOT_W'(issue);
                    if (!issue && !r_pv) n_state = S_DONE;
                end
            end
            S_LK_CHK: begin
                if (bref != '0) begin
                    n_clock = r_clock + 1'b1;
                    b_we    = 1'b1;
                    b_waddr = r_new;
                    b_wdata = {r_clock + 1'b1, bw_eff[REF_W:0]};
                    n_res   = r_new;
                    n_hit   = 1'b1;
                end else begin
                    s_we = 1'b1; s_waddr = r_hs;
                    if (r_cnt != '0) n_cnt = r_cnt - 1'b1;
                end
                n_state = S_DONE;
            end
            S_EV_SCAN: begin
                s_raddr = r_scan[SLOT_W-1:0];
                n_pv    = issue;
                n_scan  = r_scan + SLOT_W'(issue);
                n_pv2   = r_pv && sk != '0;
                b_raddr = sb;
                if (r_pv2 && bref == '0 &&
                    (!r_found || bw_eff[BI_W-1:REF_W+1] < r_best)) begin
                    n_found = 1'b1;
                    n_best  = bw_eff[BI_W-1:REF_W+1];
                    n_bests = r_ps2;
                    n_bestb = r_pb2;
                    n_bestw = bw_eff;
                end
                if (!issue && !r_pv && !r_pv2) begin
                    if (r_found) begin
                        b_we    = 1'b1;
                        b_waddr = r_bestb;
                        b_wdata = {r_bestw[BI_W-1:REF_W+1], 1'b0, r_bestw[REF_W-1:0]};
                        s_we    = 1'b1;
                        s_waddr = r_bests;
                        if (r_cnt != '0) n_cnt = r_cnt - 1'b1;
                        if (!r_ev_ins) n_hit = 1'b1;
                    end
                    n_scan  = '0;
                    n_state = r_ev_ins ? S_INS_SCAN : S_DONE;
                end
            end
            S_INS_SCAN: begin
                s_raddr = r_key[SLOT_W-1:0] + r_scan[SLOT_W-1:0];
                if (r_pv && sk == '0) begin
                    s_we    = 1'b1;
                    s_waddr = r_ps;
                    s_wdata = {r_key, r_id[BID_W-1:0]};
                    n_cnt   = r_cnt + 1'b1;
                    b_we    = 1'b1;
                    b_waddr = r_id[BID_W-1:0];
                    b_wdata = {r_clock + 1'b1, 1'b1, r_bw[REF_W-1:0]};
                    n_clock = r_clock + 1'b1;
                    n_hit   = 1'b1;
                    n_state = S_DONE;
                end else if (r_pv && sk == r_key) begin
                    n_state = S_DONE;
                end else begin
                    n_pv   = issue;
                    n_scan = r_scan + SLOT_W'(issue);
                    if (!issue && !r_pv) n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ov || i_ready) begin
                    n_ov = 1'b1;
                    n_o_st = r_st; n_o_res = r_res; n_o_hit = r_hit; n_o_cop = r_cop;
                    n_o_free = r_depth;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (b_we) n_bval[b_waddr] = 1'b1;
        if (f_we) n_fval[f_waddr] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_depth   <= DEPTH_W'(POOL_BLOCKS);
            r_cnt     <= '0;
            r_clock   <= '0;
            r_fval    <= '0;
            r_bval    <= '0;
            r_scan    <= '0;
            r_pv      <= 1'b0;
            r_pv2     <= 1'b0;
            r_clr_out <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_depth   <= n_depth;
            r_cnt     <= n_cnt;
            r_clock   <= n_clock;
            r_fval    <= n_fval;
            r_bval    <= n_bval;
            r_scan    <= n_scan;
            r_pv      <= n_pv;
            r_pv2     <= n_pv2;
            r_clr_out <= n_clr_out;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;       r_id <= n_id;       r_key <= n_key;
        r_st <= n_st;       r_res <= n_res;     r_hit <= n_hit;   r_cop <= n_cop;
        r_fv_q <= r_fval[f_raddr];
        r_bv_q <= r_bval[b_raddr];
        r_fra_q <= f_raddr;
        r_ps <= s_raddr;    r_ps2 <= r_ps;      r_pb2 <= sb;      r_hs <= n_hs;
        r_new <= n_new;     r_nw <= n_nw;       r_bw <= n_bw;
        r_found <= n_found; r_best <= n_best;   r_bests <= n_bests;
        r_bestb <= n_bestb; r_bestw <= n_bestw; r_ev_ins <= n_ev_ins;
        r_o_st <= n_o_st;   r_o_res <= n_o_res; r_o_hit <= n_o_hit;
        r_o_cop <= n_o_cop; r_o_free <= n_o_free;
    end
endmodule
